/* src/pils_pkg.sv */
// ----------------------------------------------------------------------------
// pils_pkg
// shared types and constants of the projected iterative linear solver
// ----------------------------------------------------------------------------
package pils_pkg;

  localparam int MaxSize   = 64;
  localparam int IdxW      = 6;
  localparam int DataW     = 32;
  localparam int FracBits  = 16;
  localparam int EpsQ      = 66;
  localparam int AccW      = 64;

  typedef enum logic [1:0] {
    ACT_MATRIX = 2'd0,
    ACT_ROW    = 2'd1,
    ACT_START  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_SIZE  = 2'd0,
    REG_ITER  = 2'd1,
    REG_DELTA = 2'd2,
    REG_MODE  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [5:0]        row_index;
    logic [5:0]        col_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] rhs_value;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic signed [31:0] initial_guess;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         result_index;
    logic signed [31:0] solution_value;
    logic               converged;
    logic [9:0]         sweeps_used;
    logic               last_item;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic          copy_old;   // copy solution into old for row idx
    logic          row_init;   // clear accumulator, read rhs/limits
    logic          mac;        // accumulate product for column col
    logic          div_start;  // start division of row
    logic          finish_row; // clamp, write back, update delta
    logic          clr_delta;
    logic          emit;       // present solution entry of row
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic          skip;       // column equals row
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic        div_done;
    logic        mac_idle;
    logic [30:0] delta;
  } dp_stat_t;

endpackage

/* src/pils_divider.sv */
// ----------------------------------------------------------------------------
// pils_divider
// radix-2 restoring divider for unsigned 80-bit by 33-bit, one bit per cycle
// ----------------------------------------------------------------------------
module pils_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [79:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [79:0] quotient
);
  import pils_pkg::*;

  logic [6:0]  count;
  logic        running;
  logic [33:0] rem;
  logic [79:0] quo;
  logic [32:0] den;
  logic [33:0] trial;
  logic [33:0] shifted;

  assign shifted = {rem[32:0], quo[79]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= 7'd80;
        rem     <= '0;
        quo     <= dividend;
        den     <= divisor;
      end else if (running) begin
        if (!trial[33]) begin
          rem <= trial;
          quo <= {quo[78:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[78:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* src/pils_datapath.sv */
// ----------------------------------------------------------------------------
// pils_datapath
// stores, multiply-accumulate, quotient, clamp and delta of the solver
// ----------------------------------------------------------------------------
module pils_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pils_pkg::in_word_t wr_word,
  input  logic              wr_en,
  input  logic              mode,
  input  pils_pkg::dp_cmd_t cmd,
  output pils_pkg::dp_stat_t stat,
  output logic signed [31:0] emit_value
);
  import pils_pkg::*;

  logic signed [31:0] coef_mem [MaxSize*MaxSize];
  logic signed [31:0] rhs_mem  [MaxSize];
  logic signed [31:0] lo_mem   [MaxSize];
  logic signed [31:0] hi_mem   [MaxSize];
  logic signed [31:0] sol_mem  [MaxSize];
  logic signed [31:0] old_mem  [MaxSize];

  // stage 1 reads
  logic signed [31:0] a_rd, xs_rd, xo_rd, x_rd;
  logic               mac_v1;
  logic signed [31:0] rhs_q, lo_q, hi_q, old_q, diag_q;
  // stage 2 product
  logic signed [63:0] prod;
  logic               mac_v2;
  logic signed [AccW-1:0] acc;
  logic               mac_idle;

  always_ff @(posedge clk) begin
    if (wr_en && wr_word.action == ACT_MATRIX)
      coef_mem[{wr_word.row_index, wr_word.col_index}] <= wr_word.matrix_value;
    a_rd <= coef_mem[{cmd.row, cmd.col}];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_word.action == ACT_ROW) begin
      rhs_mem[wr_word.row_index] <= wr_word.rhs_value;
      lo_mem[wr_word.row_index]  <= wr_word.lower_limit;
      hi_mem[wr_word.row_index]  <= wr_word.upper_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_old) old_mem[cmd.row] <= sol_mem[cmd.row];
    xo_rd <= old_mem[cmd.col];
  end

  logic signed [31:0] x_new;
  always_ff @(posedge clk) begin
    if (wr_en && wr_word.action == ACT_ROW)
      sol_mem[wr_word.row_index] <= wr_word.initial_guess;
    else if (cmd.finish_row)
      sol_mem[cmd.row] <= x_new;
    xs_rd      <= sol_mem[cmd.col];
    emit_value <= sol_mem[cmd.row];
  end

  assign x_rd = mode ? xs_rd : xo_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_v1 <= 1'b0;
      mac_v2 <= 1'b0;
    end else begin
      mac_v1 <= cmd.mac && !cmd.skip;
      mac_v2 <= mac_v1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_rd * x_rd;
    if (cmd.row_init) begin
      acc <= '0;
    end else if (mac_v2) begin
      acc <= acc + (prod >>> FracBits);
    end
    if (cmd.mac && cmd.skip) diag_q <= coef_mem[{cmd.row, cmd.col}];
    if (cmd.row_init) begin
      rhs_q <= rhs_mem[cmd.row];
      lo_q  <= lo_mem[cmd.row];
      hi_q  <= hi_mem[cmd.row];
      old_q <= old_mem[cmd.row];
    end
  end

  assign mac_idle = !mac_v1 && !mac_v2;

  // quotient: magnitude form, sign fixed afterwards
  logic signed [AccW:0] num;
  logic [AccW:0]        num_mag;
  logic [32:0]          den_mag;
  logic                 neg_q, num_neg, den_zero;
  logic [79:0]          quo;
  logic                 div_done;

  assign num     = {{1{rhs_q[31]}}, {(AccW-32){rhs_q[31]}}, rhs_q} - {acc[AccW-1], acc};
  assign num_neg = num[AccW];
  assign num_mag = num_neg ? -num : num;
  assign den_mag = diag_q[31] ? -{diag_q[31], diag_q} : {1'b0, diag_q};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_q    <= num_neg != diag_q[31];
      den_zero <= diag_q == '0;
    end
  end

  logic num_neg_q;
  always_ff @(posedge clk) if (cmd.div_start) num_neg_q <= num_neg;

  pils_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({num_mag[63:0], 16'd0}),
    .divisor  (den_mag),
    .done     (div_done),
    .quotient (quo)
  );

  logic signed [31:0] q_sat;
  always_comb begin
    if (den_zero) begin
      q_sat = num_neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg_q) begin
      q_sat = (quo > 80'h8000_0000) ? 32'sh8000_0000 : -quo[31:0];
    end else begin
      q_sat = (quo > 80'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    end
  end

  logic signed [31:0] q_hold;
  always_ff @(posedge clk) if (div_done) q_hold <= q_sat;

  always_comb begin
    x_new = q_hold;
    if (x_new < lo_q) x_new = lo_q;
    if (x_new > hi_q) x_new = hi_q;
  end

  // delta: |new - old| * 2^16 / max(|old|, eps), separate divider instance
  logic [32:0] diff_mag, old_mag, ddiv;
  logic signed [32:0] diff;
  assign diff     = {x_new[31], x_new} - {old_q[31], old_q};
  assign diff_mag = diff[32] ? -diff : diff;
  assign old_mag  = old_q[31] ? -{old_q[31], old_q} : {1'b0, old_q};
  assign ddiv     = (old_mag < 33'(EpsQ)) ? 33'(EpsQ) : old_mag;

  logic        d_start, d_done;
  logic [79:0] d_quo;
  logic [30:0] worst;
  logic [30:0] d_sat;

  assign d_start = cmd.finish_row;
  pils_divider u_ddiv (
    .clk      (clk),
    .rst      (rst),
    .start    (d_start),
    .dividend ({31'd0, diff_mag, 16'd0}),
    .divisor  (ddiv),
    .done     (d_done),
    .quotient (d_quo)
  );
  assign d_sat = (d_quo > 80'h7FFF_FFFF) ? 31'h7FFF_FFFF : d_quo[30:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_delta) begin
      worst <= '0;
    end else if (d_done && d_sat > worst) begin
      worst <= d_sat;
    end
  end

  assign stat = {div_done, mac_idle, worst};

endmodule

/* src/pils_control.sv */
// ----------------------------------------------------------------------------
// pils_control
// sweep sequencer: copy, per-row accumulate, divide, clamp, then emit
// ----------------------------------------------------------------------------
module pils_control (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [6:0]         active_size,
  input  logic [9:0]         max_iterations,
  input  logic [30:0]        min_delta,
  input  pils_pkg::dp_stat_t stat,
  output pils_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               strobe,
  output logic [5:0]         out_index,
  output logic               out_conv,
  output logic [9:0]         out_sweeps,
  output logic               out_last
);
  import pils_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_COPY  = 10'b0000000100,
    S_INIT  = 10'b0000001000,
    S_MAC   = 10'b0000010000,
    S_DRAIN = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_DWAIT = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t      state;
  logic [5:0]  row, col, last;
  logic [9:0]  sweeps;
  logic        conv;
  logic        emit_q;
  logic        wait_d;
  logic [6:0]  dcnt;
  logic        u_done_seen;

  always_comb begin
    if (active_size == 7'd0) last = 6'd0;
    else if (active_size > 7'd64) last = 6'd63;
    else last = 6'(active_size - 7'd1);
  end

  always_comb begin
    cmd = '0;
    cmd.row = row;
    cmd.col = col;
    cmd.skip = (col == row);
    case (state)
      S_COPY:  cmd.copy_old = 1'b1;
      S_INIT:  cmd.row_init = 1'b1;
      S_MAC:   cmd.mac = 1'b1;
      S_DRAIN: cmd.div_start = stat.mac_idle;
      S_FIN:   cmd.finish_row = 1'b1;
      S_CHECK: cmd.clr_delta = 1'b1;
      S_EMIT:  cmd.emit = 1'b1;
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      row    <= '0;
      col    <= '0;
      sweeps <= '0;
      conv   <= 1'b0;
      emit_q <= 1'b0;
      wait_d <= 1'b0;
    end else begin
      emit_q <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            sweeps <= '0;
            conv   <= 1'b0;
            row    <= '0;
            state  <= (max_iterations == 10'd0) ? S_EMIT : S_CHECK;
          end
        end
        S_CHECK: begin
          row <= '0;
          state <= S_COPY;
        end
        S_COPY: begin
          if (row == last) begin
            row   <= '0;
            state <= S_INIT;
          end else begin
            row <= row + 6'd1;
          end
        end
        S_INIT: begin
          col   <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          if (col == last) state <= S_DRAIN;
          else col <= col + 6'd1;
        end
        S_DRAIN: begin
          col <= row;
          if (stat.mac_idle) state <= S_DIV;
        end
        S_DIV: begin
          if (stat.div_done) state <= S_FIN;
        end
        S_FIN: begin
          wait_d <= 1'b0;
          state  <= S_DWAIT;
        end
        S_DWAIT: begin
          if (wait_d) begin
            if (row == last) begin
              sweeps <= sweeps + 10'd1;
              if (stat.delta < min_delta) begin
                conv  <= 1'b1;
                row   <= '0;
                state <= S_EMIT;
              end else if (sweeps + 10'd1 == max_iterations) begin
                row   <= '0;
                state <= S_EMIT;
              end else begin
                state <= S_CHECK;
              end
            end else begin
              row   <= row + 6'd1;
              state <= S_INIT;
            end
          end else if (u_done_seen) begin
            wait_d <= 1'b1;
          end
        end
        S_EMIT: begin
          emit_q <= 1'b1;
          out_index <= row;
          out_last  <= row == last;
          if (row == last) state <= S_IDLE;
          else row <= row + 6'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // delta divider completion is tracked by a countdown loaded in S_FIN
  always_ff @(posedge clk) begin
    if (rst) dcnt <= '0;
    else if (state == S_FIN) dcnt <= 7'd82;
    else if (dcnt != 7'd0) dcnt <= dcnt - 7'd1;
  end
  assign u_done_seen = (state == S_DWAIT) && (dcnt == 7'd1);

  assign strobe     = emit_q;
  assign out_conv   = conv;
  assign out_sweeps = sweeps;

endmodule

/* src/projected_iterative_linear_solver.sv */
// ----------------------------------------------------------------------------
// projected_iterative_linear_solver
// projected jacobi / gauss-seidel solver, signed q16.16, clamp per unknown
// ----------------------------------------------------------------------------
// channel   ports                              handshake
// input     start, busy, in_word               start & !busy
// result    done, out_word                     done, one cycle
// config    cfg_we, cfg_index, cfg_data        cfg_we
//
// load words are accepted one per cycle while not busy; a solve of n unknowns runs
// per sweep a copy step per row, then per row an init step, a multiply step per
// column, a drain, the quotient and the clamp and delta steps, set by the single
// multiplier and the one-bit dividers; then n result words one per cycle.
// reset clears control, delta and config registers, not the stores.
// results cannot be stalled.
module projected_iterative_linear_solver (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pils_pkg::in_word_t  in_word,
  output logic                done,
  output pils_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import pils_pkg::*;

  logic [6:0]  active_size;
  logic [9:0]  max_iterations;
  logic [30:0] min_delta;
  logic        sweep_mode;
  logic        accept, go;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic signed [31:0] emit_value;
  logic [5:0]  res_index;
  logic        res_conv;
  logic [9:0]  res_sweeps;
  logic        res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size    <= 7'd1;
      max_iterations <= 10'd128;
      min_delta      <= 31'd6554;
      sweep_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SIZE:  active_size    <= cfg_data[6:0];
        REG_ITER:  max_iterations <= cfg_data[9:0];
        REG_DELTA: min_delta      <= cfg_data;
        REG_MODE:  sweep_mode     <= cfg_data[0];
        default:   sweep_mode     <= sweep_mode;
      endcase
    end
  end

  assign accept = start && !busy;
  assign go     = accept && in_word.action == ACT_START;

  pils_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .wr_word    (in_word),
    .wr_en      (accept),
    .mode       (sweep_mode),
    .cmd        (cmd),
    .stat       (stat),
    .emit_value (emit_value)
  );

  pils_control u_ctl (
    .clk            (clk),
    .rst            (rst),
    .go             (go),
    .active_size    (active_size),
    .max_iterations (max_iterations),
    .min_delta      (min_delta),
    .stat           (stat),
    .cmd            (cmd),
    .busy           (busy),
    .strobe         (done),
    .out_index      (res_index),
    .out_conv       (res_conv),
    .out_sweeps     (res_sweeps),
    .out_last       (res_last)
  );

  assign out_word = {res_index, emit_value, res_conv, res_sweeps, res_last};

endmodule
